>>> sv/btht_pkg.sv
// ----------------------------------------------------------------------------
// btht_pkg
// Types and constants shared by the box table hit test block: command and
// result payloads, the stored box format, opcodes, status codes and states.
// ----------------------------------------------------------------------------
package btht_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int SLOT_W      = 6;
  localparam int CNT_W       = 7;
  localparam int COORD_W     = 16;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SET    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_QBOX   = 3'd3,
    OP_QPOINT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0] op;
    slot_t      entry_id;
    coord_t     box_x_min;
    coord_t     box_y_min;
    coord_t     box_x_max;
    coord_t     box_y_max;
    coord_t     point_x;
    coord_t     point_y;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    slot_t      slot_out;
    logic       last;
  } out_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } box_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_POP,
    S_ADD_WR,
    S_UPD,
    S_RESP,
    S_SCAN
  } state_t;

endpackage

>>> sv/btht_box_mem.sv
// ----------------------------------------------------------------------------
// btht_box_mem
// Box storage: one write port and one read port, read data registered.
// The read register holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module btht_box_mem import btht_pkg::*; (
  input  logic  clk,
  input  logic  we,
  input  slot_t waddr,
  input  box_t  wdata,
  input  logic  re,
  input  slot_t raddr,
  output box_t  rdata
);

  box_t mem [TABLE_DEPTH];
  box_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/btht_free_stack.sv
// ----------------------------------------------------------------------------
// btht_free_stack
// LIFO of freed slot numbers held in a memory with a fill count.
// A pop loads the top entry into a register that drives pop_slot.
// ----------------------------------------------------------------------------
module btht_free_stack import btht_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  slot_t push_slot,
  input  logic  pop,
  output slot_t pop_slot,
  output cnt_t  count
);

  slot_t mem [TABLE_DEPTH];
  slot_t pop_slot_r;
  cnt_t  count_r;
  cnt_t  count_nxt;
  cnt_t  top_idx;

  // The caller never pushes onto a full stack or pops an empty one.
  assign top_idx = count_r - cnt_t'(1);

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (pop) begin
      count_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[count_r[SLOT_W-1:0]] <= push_slot;
    end
    if (pop) begin
      pop_slot_r <= mem[top_idx[SLOT_W-1:0]];
    end
  end

  assign pop_slot = pop_slot_r;
  assign count    = count_r;

endmodule

>>> sv/box_table_hit_test_top.sv
// ----------------------------------------------------------------------------
// box_table_hit_test_top
// Table of axis-aligned boxes with slot allocation from a free stack, box
// overlap queries and point containment queries.
// ----------------------------------------------------------------------------
// Add passes allocation, a stack pop on a reused slot and the memory write
// (a full table skips to the result); set and remove pass an update state.
// Queries scan the box memory below the high-water mark one slot per cycle
// while no hit waits on a busy result register; a point hit ends the scan.
// One item is in work at a time; the next is taken the cycle after its last
// result is loaded. Synchronous rst_n empties the table; no clearing pass.
module box_table_hit_test_top import btht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  state_t state_r, state_nxt;
  in_t    cmd_r;
  cnt_t   hw_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  slot_t  slot_r;
  status_t res_status_r;
  slot_t  res_slot_r;
  cnt_t   rem_r;
  logic   s1_valid_r;
  slot_t  s1_idx_r;
  logic   pend_valid_r;
  slot_t  pend_slot_r;
  logic   out_valid_r;
  out_t   out_data_r;

  // Memory and stack connections.
  logic  mem_we;
  slot_t mem_waddr;
  box_t  mem_wdata;
  logic  mem_re;
  slot_t mem_raddr;
  box_t  mem_rdata;
  logic  stk_push;
  logic  stk_pop;
  slot_t stk_slot;
  cnt_t  stk_count;

  // Scan and control decode.
  logic  accept;
  logic  out_free;
  logic  is_box;
  logic  hit;
  logic  ovl;
  logic  cont;
  slot_t scan_addr;
  logic  scan_stall;
  logic  scan_done;
  logic  pend_set;
  logic  entry_ok;
  logic  out_load;
  out_t  out_load_data;

  btht_box_mem u_box_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  btht_free_stack u_free_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stk_push),
    .push_slot (cmd_r.entry_id),
    .pop       (stk_pop),
    .pop_slot  (stk_slot),
    .count     (stk_count)
  );

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign is_box    = (cmd_r.op == OP_QBOX);
  assign mem_wdata = '{x_min: cmd_r.box_x_min, y_min: cmd_r.box_y_min,
                       x_max: cmd_r.box_x_max, y_max: cmd_r.box_y_max};
  assign entry_ok  = valid_r[cmd_r.entry_id];

  // Box mode walks upward from slot 0, point mode downward from the top.
  always_comb begin
    ovl  = (mem_rdata.x_min <= cmd_r.box_x_max) && (cmd_r.box_x_min <= mem_rdata.x_max) &&
           (mem_rdata.y_min <= cmd_r.box_y_max) && (cmd_r.box_y_min <= mem_rdata.y_max);
    cont = (mem_rdata.x_min <= cmd_r.point_x) && (cmd_r.point_x <= mem_rdata.x_max) &&
           (mem_rdata.y_min <= cmd_r.point_y) && (cmd_r.point_y <= mem_rdata.y_max);
    hit  = s1_valid_r && valid_r[s1_idx_r] && (is_box ? ovl : cont);
    scan_addr = is_box ? slot_t'(hw_r - rem_r) : slot_t'(rem_r - cnt_t'(1));
    // A box hit must push out the held hit; a point hit is the answer itself.
    scan_stall = hit && !out_free && (pend_valid_r || !is_box);
    scan_done  = (hit && !is_box && out_free) ||
                 (!s1_valid_r && (rem_r == '0) && out_free);
    pend_set   = hit && is_box && !scan_stall;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_ADD:                state_nxt = S_ALLOC;
            OP_SET, OP_REMOVE:     state_nxt = S_UPD;
            OP_QBOX, OP_QPOINT:    state_nxt = S_SCAN;
            default:               state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (stk_count != '0) begin
          state_nxt = S_POP;
        end else if (hw_r != cnt_t'(TABLE_DEPTH)) begin
          state_nxt = S_ADD_WR;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_POP:    state_nxt = S_ADD_WR;
      S_ADD_WR: state_nxt = S_RESP;
      S_UPD:    state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = slot_r;
    mem_re        = 1'b0;
    mem_raddr     = scan_addr;
    stk_push      = 1'b0;
    stk_pop       = 1'b0;
    out_load      = 1'b0;
    out_load_data = '{status: res_status_r, slot_out: res_slot_r, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_ALLOC: begin
        stk_pop = (stk_count != '0);
      end
      S_ADD_WR: begin
        mem_we = 1'b1;
      end
      S_UPD: begin
        if (cmd_r.op == OP_SET) begin
          mem_we    = entry_ok;
          mem_waddr = cmd_r.entry_id;
        end else begin
          stk_push = entry_ok && (stk_count != cnt_t'(TABLE_DEPTH));
        end
      end
      S_RESP: begin
        out_load = out_free;
      end
      S_SCAN: begin
        mem_re = !scan_stall && !(hit && !is_box) && (rem_r != '0);
        if (hit && !is_box) begin
          out_load      = out_free;
          out_load_data = '{status: ST_OK, slot_out: s1_idx_r, last: 1'b1};
        end else if (pend_set && pend_valid_r) begin
          out_load      = 1'b1;
          out_load_data = '{status: ST_OK, slot_out: pend_slot_r, last: 1'b0};
        end else if (!s1_valid_r && (rem_r == '0)) begin
          out_load = out_free;
          if (is_box && pend_valid_r) begin
            out_load_data = '{status: ST_OK, slot_out: pend_slot_r, last: 1'b1};
          end else begin
            out_load_data = '{status: ST_NOMATCH, slot_out: '0, last: 1'b1};
          end
        end
      end
      default: ;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hw_r         <= '0;
      valid_r      <= '0;
      rem_r        <= '0;
      s1_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        rem_r        <= hw_r;
        s1_valid_r   <= 1'b0;
        pend_valid_r <= 1'b0;
      end
      if (state_r == S_ALLOC && stk_count == '0 && hw_r != cnt_t'(TABLE_DEPTH)) begin
        hw_r <= hw_r + cnt_t'(1);
      end
      if (state_r == S_ADD_WR) begin
        valid_r[slot_r] <= 1'b1;
      end
      if (stk_push) begin
        valid_r[cmd_r.entry_id] <= 1'b0;
      end
      if (state_r == S_SCAN) begin
        if (scan_done) begin
          s1_valid_r <= 1'b0;
        end else if (mem_re) begin
          s1_valid_r <= 1'b1;
          rem_r      <= rem_r - cnt_t'(1);
        end else if (!scan_stall) begin
          s1_valid_r <= 1'b0;
        end
        if (pend_set) begin
          pend_valid_r <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
    if (out_load) begin
      out_data_r <= out_load_data;
    end
    if (mem_re) begin
      s1_idx_r <= scan_addr;
    end
    if (pend_set) begin
      pend_slot_r <= s1_idx_r;
    end
    case (state_r)
      S_ALLOC: begin
        slot_r       <= slot_t'(hw_r);
        res_status_r <= ST_FULL;
        res_slot_r   <= '0;
      end
      S_POP: begin
        slot_r <= stk_slot;
      end
      S_ADD_WR: begin
        res_status_r <= ST_OK;
        res_slot_r   <= slot_r;
      end
      S_UPD: begin
        res_slot_r <= cmd_r.entry_id;
        if ((cmd_r.op == OP_SET) ? entry_ok : stk_push) begin
          res_status_r <= ST_OK;
        end else begin
          res_status_r <= ST_INVALID;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> dv/btht_result_checker.sv
// ----------------------------------------------------------------------------
// btht_result_checker
// Watches the command and result channels of the box table. Each accepted
// command updates a private copy of the table, free stack and high-water mark
// and queues the results it should cause; each result transfer is compared
// field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module btht_result_checker import btht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   fail_count,
  output int   pending,
  output int   cmds_seen,
  output int   results_seen,
  output int   full_seen,
  output int   nomatch_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    int x0;
    int y0;
    int x1;
    int y1;
  } rect_t;

  rect_t boxes      [TABLE_DEPTH];
  bit    live       [TABLE_DEPTH];
  int    free_stack [TABLE_DEPTH];
  int    high_water;
  int    free_count;
  out_t  pending_results [$];

  function automatic void queue_result(status_t st, int slot, bit fin);
    out_t r;
    r.status   = st;
    r.slot_out = slot_t'(slot);
    r.last     = fin;
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Applies one command to the table copy and queues the results it causes.
  function automatic void predict_table_op(in_t cmd);
    rect_t q;
    int    px;
    int    py;
    int    slot;
    int    hits [$];
    q.x0 = int'(cmd.box_x_min);
    q.y0 = int'(cmd.box_y_min);
    q.x1 = int'(cmd.box_x_max);
    q.y1 = int'(cmd.box_y_max);
    px   = int'(cmd.point_x);
    py   = int'(cmd.point_y);
    case (cmd.op)
      OP_ADD: begin
        slot = -1;
        if (free_count > 0) begin
          free_count--;
          slot = free_stack[free_count];
        end else if (high_water < TABLE_DEPTH) begin
          slot = high_water;
          high_water++;
        end
        if (slot < 0) begin
          queue_result(ST_FULL, 0, 1'b1);
        end else begin
          boxes[slot] = q;
          live[slot]  = 1'b1;
          queue_result(ST_OK, slot, 1'b1);
        end
      end
      OP_SET: begin
        if (!live[cmd.entry_id]) begin
          queue_result(ST_INVALID, cmd.entry_id, 1'b1);
        end else begin
          boxes[cmd.entry_id] = q;
          queue_result(ST_OK, cmd.entry_id, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (!live[cmd.entry_id] || free_count >= TABLE_DEPTH) begin
          queue_result(ST_INVALID, cmd.entry_id, 1'b1);
        end else begin
          live[cmd.entry_id] = 1'b0;
          free_stack[free_count] = cmd.entry_id;
          free_count++;
          queue_result(ST_OK, cmd.entry_id, 1'b1);
        end
      end
      OP_QBOX: begin
        for (int i = 0; i < high_water; i++) begin
          if (live[i] && boxes[i].x0 <= q.x1 && q.x0 <= boxes[i].x1 &&
              boxes[i].y0 <= q.y1 && q.y0 <= boxes[i].y1) begin
            hits.insert(hits.size(), i);
          end
        end
        if (hits.size() == 0) begin
          queue_result(ST_NOMATCH, 0, 1'b1);
        end else begin
          foreach (hits[k]) queue_result(ST_OK, hits[k], k == hits.size() - 1);
        end
      end
      OP_QPOINT: begin
        slot = -1;
        // Highest containing slot wins, so scan downward and stop at the first.
        for (int i = high_water - 1; i >= 0 && slot < 0; i--) begin
          if (live[i] && boxes[i].x0 <= px && px <= boxes[i].x1 &&
              boxes[i].y0 <= py && py <= boxes[i].y1) begin
            slot = i;
          end
        end
        if (slot < 0) queue_result(ST_NOMATCH, 0, 1'b1);
        else queue_result(ST_OK, slot, 1'b1);
      end
      default: begin
        // Unused opcodes produce nothing and leave the table alone.
      end
    endcase
  endfunction

  function automatic void note_failure(bit unexpected, out_t want, out_t got);
    fail_count++;
    if (fail_count <= 10) begin
      if (unexpected) begin
        $display("%0t: result with nothing outstanding: status %0d slot %0d last %0d",
                 $realtime, got.status, got.slot_out, got.last);
      end else begin
        $display("%0t: mismatch: expected status %0d slot %0d last %0d, got %0d %0d %0d",
                 $realtime, want.status, want.slot_out, want.last,
                 got.status, got.slot_out, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (live[i]) live[i] = 1'b0;
      high_water   = 0;
      free_count   = 0;
      fail_count   = 0;
      cmds_seen    = 0;
      results_seen = 0;
      full_seen    = 0;
      nomatch_seen = 0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        cmds_seen++;
        predict_table_op(in_data);
      end
      if (out_valid === 1'b1 && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          note_failure(1'b1, '0, out_data);
        end else begin
          want = pending_results.pop_front();
          if (want.status == ST_FULL) full_seen++;
          if (want.status == ST_NOMATCH) nomatch_seen++;
          if (out_data.status !== want.status || out_data.slot_out !== want.slot_out ||
              out_data.last !== want.last) begin
            note_failure(1'b0, want, out_data);
          end
        end
      end
    end
    pending = pending_results.size();
  end

endmodule

>>> dv/box_table_hit_test_top_test.sv
// ----------------------------------------------------------------------------
// box_table_hit_test_top_test
// Drives the box table with a directed opening (empty table, invalid slots,
// extreme and inverted boxes, free-stack reuse, unused opcodes) followed by
// random command mixes under three idling patterns, a table-fill phase and a
// long receiver hold. The checker module predicts and compares all results.
// ----------------------------------------------------------------------------
module box_table_hit_test_top_test import btht_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STALL_LIMIT  = 3000;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 100;
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int fail_count;
  int pending;
  int cmds_seen;
  int results_seen;
  int full_seen;
  int nomatch_seen;

  int tx_idle_pct = 35;
  int rx_idle_pct = 49;
  bit hold_req    = 1'b0;
  int slots_used  = 0;
  int stall_cycles;

  box_table_hit_test_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  btht_result_checker results_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .cmds_seen   (cmds_seen),
    .results_seen(results_seen),
    .full_seen   (full_seen),
    .nomatch_seen(nomatch_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, with one long hold on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("No transfer for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_cmd(in_t cmd);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_t noise_cmd();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_t)-1:0];
  endfunction

  function automatic in_t cmd_of(logic [2:0] op, int id, int x0, int y0, int x1, int y1,
                                 int px, int py);
    in_t cmd;
    cmd.op        = op;
    cmd.entry_id  = slot_t'(id);
    cmd.box_x_min = coord_t'(x0);
    cmd.box_y_min = coord_t'(y0);
    cmd.box_x_max = coord_t'(x1);
    cmd.box_y_max = coord_t'(y1);
    cmd.point_x   = coord_t'(px);
    cmd.point_y   = coord_t'(py);
    return cmd;
  endfunction

  // Mostly compact boxes near the origin so that queries find overlaps; some
  // keep full-range noise corners, some are inverted on one axis.
  function automatic in_t with_box(in_t cmd, int span);
    int style;
    int cx;
    int cy;
    int w;
    int h;
    style = $urandom_range(0, 9);
    cx    = int'($urandom_range(0, 2 * span)) - span;
    cy    = int'($urandom_range(0, 2 * span)) - span;
    w     = $urandom_range(0, span / 2);
    h     = $urandom_range(0, span / 2);
    if (style == 0) return cmd;
    cmd.box_x_min = coord_t'(cx);
    cmd.box_x_max = coord_t'(cx + w);
    cmd.box_y_min = coord_t'(cy);
    cmd.box_y_max = coord_t'(cy + h);
    if (style == 1) begin
      cmd.box_x_min = coord_t'(cx + w + 1);
      cmd.box_x_max = coord_t'(cx);
    end
    if (style == 2) begin
      cmd.box_y_min = coord_t'(cy + h + 1);
      cmd.box_y_max = coord_t'(cy);
    end
    return cmd;
  endfunction

  function automatic slot_t pick_slot();
    if (slots_used > 0 && $urandom_range(0, 9) != 0) begin
      return slot_t'($urandom_range(0, slots_used - 1));
    end
    return slot_t'($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  // Sends count commands of known opcodes; unused opcodes are mixed in extra.
  task automatic run_random(int count, int w_add, int w_set, int w_rem, int w_qry);
    in_t cmd;
    int  pick;
    int  sent;
    sent = 0;
    while (sent < count) begin
      cmd  = noise_cmd();
      pick = $urandom_range(0, w_add + w_set + w_rem + 2 * w_qry - 1);
      if ($urandom_range(0, 99) < 3) begin
        cmd.op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
      end else begin
        sent++;
        if (pick < w_add) begin
          cmd.op = OP_ADD;
          cmd = with_box(cmd, 300);
          if (slots_used < TABLE_DEPTH) slots_used++;
        end else if (pick < w_add + w_set) begin
          cmd.op = OP_SET;
          cmd.entry_id = pick_slot();
          cmd = with_box(cmd, 300);
        end else if (pick < w_add + w_set + w_rem) begin
          cmd.op = OP_REMOVE;
          cmd.entry_id = pick_slot();
        end else if (pick < w_add + w_set + w_rem + w_qry) begin
          cmd.op = OP_QBOX;
          cmd = with_box(cmd, 300);
        end else begin
          cmd.op = OP_QPOINT;
          if ($urandom_range(0, 9) != 0) begin
            cmd.point_x = coord_t'(int'($urandom_range(0, 700)) - 350);
            cmd.point_y = coord_t'(int'($urandom_range(0, 700)) - 350);
          end
        end
      end
      send_cmd(cmd);
    end
  endtask

  initial begin
    in_t cmd;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty table, invalid slots, extreme and inverted boxes, boundaries.
    send_cmd(cmd_of(OP_QBOX, 0, -32768, -32768, 32767, 32767, 0, 0));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_SET, 0, 1, 2, 3, 4, 0, 0));
    send_cmd(cmd_of(OP_REMOVE, 63, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_ADD, 0, -32768, -32768, 32767, 32767, 0, 0));
    send_cmd(cmd_of(OP_ADD, 0, 0, 0, 10, 10, 0, 0));
    send_cmd(cmd_of(OP_ADD, 0, 10, 10, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_ADD, 0, -5, -5, -5, -5, 0, 0));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, 5, 5));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, -32768, 32767));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, 10, 10));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, -5, -5));
    send_cmd(cmd_of(OP_QBOX, 0, 10, 10, 20, 20, 0, 0));
    send_cmd(cmd_of(OP_QBOX, 0, 0, 0, 10, 10, 0, 0));
    send_cmd(cmd_of(OP_QBOX, 0, 20, 20, -20, -20, 0, 0));
    send_cmd(cmd_of(OP_SET, 1, 100, 100, 200, 200, 0, 0));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, 150, 200));
    send_cmd(cmd_of(OP_REMOVE, 1, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_REMOVE, 1, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_SET, 1, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_REMOVE, 3, 0, 0, 0, 0, 0, 0));
    // Freed slots come back last in, first out, before the high-water grows.
    send_cmd(cmd_of(OP_ADD, 0, -100, -100, 100, 100, 0, 0));
    send_cmd(cmd_of(OP_ADD, 0, 32767, 32767, 32767, 32767, 0, 0));
    send_cmd(cmd_of(OP_ADD, 0, -32768, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, 32767, 32767));
    for (int op = OP_BAD_FIRST; op <= OP_BAD_LAST; op++) begin
      send_cmd(cmd_of(op[2:0], 0, 0, 0, 0, 0, 0, 0));
    end
    slots_used = 5;

    run_random(45, 30, 15, 10, 20);
    // The receiver stops for a long while; the table must stall its input.
    hold_req = 1'b1;
    run_random(45, 25, 15, 15, 20);

    tx_idle_pct = 49;
    rx_idle_pct = 35;
    // More adds than the table holds, so the full case is reached.
    repeat (70) begin
      cmd = noise_cmd();
      cmd.op = OP_ADD;
      send_cmd(with_box(cmd, 300));
    end
    slots_used = TABLE_DEPTH;
    send_cmd(cmd_of(OP_QBOX, 0, -32768, -32768, 32767, 32767, 0, 0));
    send_cmd(cmd_of(OP_QBOX, 0, -150, -150, 150, 150, 0, 0));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(cmd_of(OP_QPOINT, 0, 0, 0, 0, 0, 32767, -32768));
    run_random(40, 15, 10, 40, 15);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(78, 25, 15, 15, 20);
    send_cmd(cmd_of(OP_QBOX, 0, -32768, -32768, 32767, 32767, 0, 0));
    send_cmd(cmd_of(OP_QBOX, 0, 32767, 32767, -32768, -32768, 0, 0));
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d commands giving %0d results (%0d table-full, %0d no-match)",
             cmds_seen, results_seen, full_seen, nomatch_seen);
    $display("under sender and receiver idling, a long receiver hold and a full table.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
sv/btht_pkg.sv
sv/btht_box_mem.sv
sv/btht_free_stack.sv
sv/box_table_hit_test_top.sv
dv/btht_result_checker.sv
dv/box_table_hit_test_top_test.sv
